// ----- design/rlcp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlcp_pkg
// Shared types and constants of the RGB level command parser.
// ----------------------------------------------------------------------------
package rlcp_pkg;

  localparam logic [7:0] ChrRedUp   = 8'h52;
  localparam logic [7:0] ChrRedLo   = 8'h72;
  localparam logic [7:0] ChrGreenUp = 8'h47;
  localparam logic [7:0] ChrGreenLo = 8'h67;
  localparam logic [7:0] ChrBlueUp  = 8'h42;
  localparam logic [7:0] ChrBlueLo  = 8'h62;
  localparam logic [7:0] ChrZero    = 8'h30;
  localparam logic [7:0] ChrNine    = 8'h39;
  localparam logic [1:0] AsciiDigitHi = 2'b11;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } channel_e;

  // next digit expected
  typedef enum logic [1:0] {
    POS_IDLE = 2'd0,
    POS_HUND = 2'd1,
    POS_TENS = 2'd2,
    POS_ONES = 2'd3
  } pos_e;

  // one complete command between parser and executor
  typedef struct packed {
    channel_e    channel;
    logic [3:0]  hund;
    logic [3:0]  tens;
    logic [3:0]  ones;
  } cmd_t;

  function automatic channel_e letter_channel(input logic [7:0] b);
    channel_e ch;
    ch = CH_NONE;
    if (b == ChrRedUp || b == ChrRedLo) ch = CH_RED;
    else if (b == ChrGreenUp || b == ChrGreenLo) ch = CH_GREEN;
    else if (b == ChrBlueUp || b == ChrBlueLo) ch = CH_BLUE;
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- design/rlcp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlcp_front
// Byte parser: tracks letter and digit phases, pushes complete commands.
// ----------------------------------------------------------------------------
module rlcp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output rlcp_pkg::cmd_t     cmd_o
);
  import rlcp_pkg::*;

  pos_e       pos_q, pos_d;
  channel_e   chan_q, chan_d;
  logic [3:0] hund_q, hund_d;
  logic [3:0] tens_q, tens_d;
  channel_e   byte_ch;
  logic       is_digit;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign byte_ch    = letter_channel(rx_byte_i);
  assign is_digit   = rx_byte_i inside {[ChrZero:ChrNine]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_IDLE;
      chan_q <= CH_RED;
    end else begin
      pos_q  <= pos_d;
      chan_q <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hund_q <= hund_d;
    tens_q <= tens_d;
  end

  always_comb begin
    pos_d  = pos_q;
    chan_d = chan_q;
    hund_d = hund_q;
    tens_d = tens_q;
    push_o = 1'b0;
    if (accept) begin
      if (byte_ch != CH_NONE) begin
        // a letter always restarts a command
        chan_d = byte_ch;
        pos_d  = POS_HUND;
      end else if (pos_q != POS_IDLE) begin
        if (!is_digit) begin
          pos_d = POS_IDLE;
        end else begin
          case (pos_q)
            POS_HUND: begin
              hund_d = rx_byte_i[3:0];
              pos_d  = POS_TENS;
            end
            POS_TENS: begin
              tens_d = rx_byte_i[3:0];
              pos_d  = POS_ONES;
            end
            POS_ONES: begin
              push_o = 1'b1;
              pos_d  = POS_IDLE;
            end
            default: begin
              pos_d = POS_IDLE;
            end
          endcase
        end
      end
    end
  end

  assign cmd_o.channel = chan_q;
  assign cmd_o.hund    = hund_q;
  assign cmd_o.tens    = tens_q;
  assign cmd_o.ones    = rx_byte_i[3:0];

endmodule
`default_nettype wire

// ----- design/rlcp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlcp_queue
// Small register FIFO of parsed commands between parser and executor.
// ----------------------------------------------------------------------------
module rlcp_queue #(
  parameter int Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rlcp_pkg::cmd_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output rlcp_pkg::cmd_t       pop_data_o
);
  import rlcp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/rlcp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rlcp_back
// Executor: forms the decimal level, updates channel levels, holds the result.
// ----------------------------------------------------------------------------
module rlcp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire rlcp_pkg::cmd_t  cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           channel_o,
  output logic [7:0]           level_o,
  output logic [5:0]           digit_hundreds_o,
  output logic [5:0]           digit_tens_o,
  output logic [5:0]           digit_ones_o,
  output logic [7:0]           red_level_o,
  output logic [7:0]           green_level_o,
  output logic [7:0]           blue_level_o
);
  import rlcp_pkg::*;

  logic       valid_q;
  logic [7:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [9:0] value;
  logic [7:0] lvl;

  assign pop_o = !q_empty_i && (!valid_q || out_ready_i);

  assign value = 10'(cmd_i.hund) * 10'd100 + 10'(cmd_i.tens) * 10'd10 + 10'(cmd_i.ones);
  // anything above a byte clears to zero
  assign lvl   = (value > 10'd255) ? 8'd0 : value[7:0];

  always_comb begin
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    case (cmd_i.channel)
      CH_RED:   red_d   = lvl;
      CH_GREEN: green_d = lvl;
      default:  blue_d  = lvl;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      red_q   <= 8'd0;
      green_q <= 8'd0;
      blue_q  <= 8'd0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        red_q   <= red_d;
        green_q <= green_d;
        blue_q  <= blue_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      channel_o        <= cmd_i.channel;
      level_o          <= lvl;
      digit_hundreds_o <= {AsciiDigitHi, cmd_i.hund};
      digit_tens_o     <= {AsciiDigitHi, cmd_i.tens};
      digit_ones_o     <= {AsciiDigitHi, cmd_i.ones};
    end
  end

  assign out_valid_o   = valid_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

endmodule
`default_nettype wire

// ----- design/rgb_level_command_parser_core.sv -----
`default_nettype none
// Path: a completed command is queued, then popped into the result registers.
// Throughput: one byte per cycle; one command retired per cycle while unstalled.
// Input stalls only while the command queue (QueueDepth entries) is full.
// Reset: parser idle, channel levels cleared to zero, queue and output empty.
// ----------------------------------------------------------------------------
// rgb_level_command_parser_core
// Parses letter plus three digit commands and updates RGB brightness levels.
// ----------------------------------------------------------------------------
module rgb_level_command_parser_core #(
  parameter int QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      channel_o,
  output logic [7:0]      level_o,
  output logic [5:0]      digit_hundreds_o,
  output logic [5:0]      digit_tens_o,
  output logic [5:0]      digit_ones_o,
  output logic [7:0]      red_level_o,
  output logic [7:0]      green_level_o,
  output logic [7:0]      blue_level_o
);
  import rlcp_pkg::*;

  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, pop_cmd;

  rlcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rlcp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_cmd)
  );

  rlcp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .cmd_i            (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .channel_o        (channel_o),
    .level_o          (level_o),
    .digit_hundreds_o (digit_hundreds_o),
    .digit_tens_o     (digit_tens_o),
    .digit_ones_o     (digit_ones_o),
    .red_level_o      (red_level_o),
    .green_level_o    (green_level_o),
    .blue_level_o     (blue_level_o)
  );

  // a completed command never meets a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("command pushed into full queue");

  a_level_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((channel_o == CH_RED && level_o == red_level_o) ||
                     (channel_o == CH_GREEN && level_o == green_level_o) ||
                     (channel_o == CH_BLUE && level_o == blue_level_o)))
    else $error("result level differs from stored level");

  a_ascii_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_hundreds_o[5:4] == AsciiDigitHi &&
                     digit_tens_o[5:4] == AsciiDigitHi &&
                     digit_ones_o[5:4] == AsciiDigitHi))
    else $error("result digit outside ascii digit range");

  // a fresh result only follows a queued command
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(!q_empty))
    else $error("result without queued command");

endmodule
`default_nettype wire

// ----- test/rgb_level_command_parser_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_level_command_parser_core_tb
// Feeds letter plus three digit commands, broken commands and noise bytes into
// the parser and checks every level update against a software copy of the
// parser state, under varying sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module rgb_level_command_parser_core_tb;
  import rlcp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomBytes   = 1430;

  typedef struct {
    channel_e   chan;
    logic [7:0] level;
    logic [5:0] hund;
    logic [5:0] tens;
    logic [5:0] ones;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } level_update_t;

  class level_tracker;
    pos_e          position;
    channel_e      cmd_chan;
    logic [3:0]    digits[3];
    logic [7:0]    levels[3];
    level_update_t expected_updates[$];
    int            mismatches;
    int            updates_seen;
    int            zeroed;

    function new();
      position = POS_IDLE;
      cmd_chan = CH_RED;
      foreach (levels[i]) levels[i] = 8'd0;
      foreach (digits[i]) digits[i] = 4'd0;
      mismatches   = 0;
      updates_seen = 0;
      zeroed       = 0;
    endfunction

    // works out what one accepted request byte does to the parser
    function void note_byte(logic [7:0] b);
      channel_e      ch;
      int            value;
      level_update_t upd;
      ch = CH_NONE;
      case (b)
        ChrRedUp, ChrRedLo:     ch = CH_RED;
        ChrGreenUp, ChrGreenLo: ch = CH_GREEN;
        ChrBlueUp, ChrBlueLo:   ch = CH_BLUE;
        default:                ch = CH_NONE;
      endcase
      if (ch != CH_NONE) begin
        cmd_chan = ch;
        position = POS_HUND;
        return;
      end
      if (position == POS_IDLE) return;
      if (b < ChrZero || b > ChrNine) begin
        position = POS_IDLE;
        return;
      end
      case (position)
        POS_HUND: begin
          digits[0] = b[3:0];
          position  = POS_TENS;
        end
        POS_TENS: begin
          digits[1] = b[3:0];
          position  = POS_ONES;
        end
        default: begin
          digits[2] = b[3:0];
          position  = POS_IDLE;
          value = digits[0] * 100 + digits[1] * 10 + digits[2];
          // anything past a byte, 256 included, reads back as zero
          if (value > 255) begin
            value = 0;
            zeroed++;
          end
          levels[int'(cmd_chan)] = value[7:0];
          upd.chan  = cmd_chan;
          upd.level = value[7:0];
          upd.hund  = {AsciiDigitHi, digits[0]};
          upd.tens  = {AsciiDigitHi, digits[1]};
          upd.ones  = {AsciiDigitHi, digits[2]};
          upd.red   = levels[0];
          upd.green = levels[1];
          upd.blue  = levels[2];
          expected_updates.push_back(upd);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_update(level_update_t got);
      level_update_t want;
      updates_seen++;
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: level update with no command pending, channel %0d level %0d",
                   $time, got.chan, got.level);
        return;
      end
      want = expected_updates.pop_front();
      compare_field("channel", 8'(want.chan), 8'(got.chan));
      compare_field("level", want.level, got.level);
      compare_field("digit_hundreds", 8'(want.hund), 8'(got.hund));
      compare_field("digit_tens", 8'(want.tens), 8'(got.tens));
      compare_field("digit_ones", 8'(want.ones), 8'(got.ones));
      compare_field("red_level", want.red, got.red);
      compare_field("green_level", want.green, got.green);
      compare_field("blue_level", want.blue, got.blue);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] channel_o;
  logic [7:0] level_o;
  logic [5:0] digit_hundreds_o;
  logic [5:0] digit_tens_o;
  logic [5:0] digit_ones_o;
  logic [7:0] red_level_o;
  logic [7:0] green_level_o;
  logic [7:0] blue_level_o;

  level_tracker board = new();
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           bytes_sent = 0;
  int           cmd_bytes = 0;
  int           quiet_cycles = 0;

  rgb_level_command_parser_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_o       (channel_o),
    .level_o         (level_o),
    .digit_hundreds_o(digit_hundreds_o),
    .digit_tens_o    (digit_tens_o),
    .digit_ones_o    (digit_ones_o),
    .red_level_o     (red_level_o),
    .green_level_o   (green_level_o),
    .blue_level_o    (blue_level_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result side: check on handshake, then pick next cycle's ready
  always @(posedge clk_i) begin
    level_update_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.chan  = channel_e'(channel_o);
      got.level = level_o;
      got.hund  = digit_hundreds_o;
      got.tens  = digit_tens_o;
      got.ones  = digit_ones_o;
      got.red   = red_level_o;
      got.green = green_level_o;
      got.blue  = blue_level_o;
      board.check_update(got);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no request or update moved for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high between back-to-back requests, dropped only for a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_command();
    logic [7:0] letters[6];
    int         kind;
    int         break_at;
    logic [7:0] d;
    letters = '{ChrRedUp, ChrRedLo, ChrGreenUp, ChrGreenLo, ChrBlueUp, ChrBlueLo};
    kind     = $urandom_range(99);
    break_at = (kind >= 80 && kind < 92) ? $urandom_range(2) : 3;
    if (kind >= 92) send_byte(8'($urandom_range(255)));
    send_byte(letters[$urandom_range(5)]);
    cmd_bytes++;
    for (int k = 0; k < 3; k++) begin
      if (k == break_at) begin
        // arbitrary byte mid-command: usually drops it, letters restart it
        send_byte(8'($urandom_range(255)));
        cmd_bytes++;
        return;
      end
      if (k == 0 && $urandom_range(1) == 0) d = ChrZero + 8'($urandom_range(2));
      else d = ChrZero + 8'($urandom_range(9));
      send_byte(d);
      cmd_bytes++;
    end
  endtask

  // the last request is already taken, so valid drops before waiting
  task automatic wait_for_updates();
    in_valid_i <= 1'b0;
    while (board.expected_updates.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    string directed;
    int    phase_idle[4];
    int    phase_stall[4];
    directed    = "R255g000B256b9r999G1/:";
    phase_idle  = '{0, 49, 0, 18};
    phase_stall = '{0, 0, 49, 18};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, every letter, restart, broken command, idle noise
    for (int i = 0; i < directed.len(); i++) send_byte(directed[i]);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_for_updates();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      while (cmd_bytes < (RandomBytes * (p + 1)) / 4) send_command();
      // hold the sender until the pipe is empty
      wait_for_updates();
    end

    in_valid_i <= 1'b0;
    wait_for_updates();
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes, checked %0d level updates, %0d of them forced to zero",
             bytes_sent, board.updates_seen, board.zeroed);
    $display("phases: free flow, sender gaps, receiver stalls, both");
    if (board.mismatches == 0 && board.expected_updates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d updates never seen", board.mismatches,
               board.expected_updates.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rlcp_pkg.sv
design/rlcp_front.sv
design/rlcp_queue.sv
design/rlcp_back.sv
design/rgb_level_command_parser_core.sv
test/rgb_level_command_parser_core_tb.sv
